[rtl/pnwc_pkg.sv]
// Shared types and constants for the nearest weighted palette color search.
// Used by pnwc_front, pnwc_back and the top level; depends on nothing else.
`timescale 1ns / 1ps

package pnwc_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

   localparam int INDEX_W = 8;
   localparam int COLOR_W = 8;
   localparam int RGB_W = 3 * COLOR_W;
   localparam int SQ_W = 2 * COLOR_W;
   localparam int DIST_W = 23;

   localparam logic [DIST_W-1:0] START_MIN = 23'd1000000;
   localparam logic [6:0] WEIGHT_RED = 7'd30;
   localparam logic [6:0] WEIGHT_GREEN = 7'd59;
   localparam logic [6:0] WEIGHT_BLUE = 7'd11;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_RGB    = 2'd1,
      FUNC_PACKED = 2'd2,
      FUNC_565    = 2'd3
   } func_type;

   // One decoded request as it waits between the front and the back.
   typedef struct packed {
      logic                is_query;
      logic [INDEX_W-1:0]  entry_index;
      logic [COLOR_W-1:0]  red;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  blue;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_RESULT = 2'd2
   } state_type;

endpackage

[rtl/pnwc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the palette store.
`timescale 1ns / 1ps

module pnwc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pnwc_front.sv]
// Front part: accepts requests, decodes the function code and widens the
// query color, then holds decoded requests in a short queue. Uses pnwc_pkg.
`timescale 1ns / 1ps

module pnwc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [1:0]              req_tuser,
   input  logic [55:0]             req_tdata,
   output logic                    cmd_valid,
   output pnwc_pkg::cmd_type       cmd,
   input  logic                    cmd_pop
);

   pnwc_pkg::cmd_type             dec_cmd;
   pnwc_pkg::func_type            func;
   logic [23:0]                   pixel;
   pnwc_pkg::cmd_type             q_ff [pnwc_pkg::QUEUE_DEPTH];
   logic [pnwc_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pnwc_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pnwc_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                          push;
   logic                          pop;

   assign func  = pnwc_pkg::func_type'(req_tuser);
   assign pixel = req_tdata[55:32];

   always_comb begin
      dec_cmd.entry_index = req_tdata[7:0];
      unique case (func)
         pnwc_pkg::FUNC_WRITE: begin
            dec_cmd.is_query = 1'b0;
            dec_cmd.red      = req_tdata[15:8];
            dec_cmd.green    = req_tdata[23:16];
            dec_cmd.blue     = req_tdata[31:24];
         end
         pnwc_pkg::FUNC_RGB: begin
            dec_cmd.is_query = 1'b1;
            dec_cmd.red      = req_tdata[15:8];
            dec_cmd.green    = req_tdata[23:16];
            dec_cmd.blue     = req_tdata[31:24];
         end
         pnwc_pkg::FUNC_PACKED: begin
            dec_cmd.is_query = 1'b1;
            dec_cmd.red      = {pixel[23:19], 3'b000};
            dec_cmd.green    = {pixel[15:10], 2'b00};
            dec_cmd.blue     = {pixel[7:3], 3'b000};
         end
         pnwc_pkg::FUNC_565: begin
            dec_cmd.is_query = 1'b1;
            dec_cmd.red      = {pixel[15:11], 3'b000};
            dec_cmd.green    = {pixel[10:5], 2'b00};
            dec_cmd.blue     = {pixel[4:0], 3'b000};
         end
         default: begin
            dec_cmd.is_query = 1'b0;
            dec_cmd.red      = '0;
            dec_cmd.green    = '0;
            dec_cmd.blue     = '0;
         end
      endcase
   end

   assign req_tready = (count_ff != pnwc_pkg::QCNT_W'(pnwc_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pnwc_pkg::QPTR_W'(pnwc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pnwc_pkg::QPTR_W'(pnwc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pnwc_pkg::QCNT_W'(pnwc_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not raise the queue count");

endmodule

[rtl/pnwc_back.sv]
// Back part: applies palette writes and runs the search, one palette entry
// per cycle through a three-stage distance pipeline. Uses pnwc_pkg, pnwc_ram.
`timescale 1ns / 1ps

module pnwc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  pnwc_pkg::cmd_type    cmd,
   output logic                 cmd_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata
);

   pnwc_pkg::state_type                 state_ff, state_in;
   logic [pnwc_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [pnwc_pkg::PALETTE_ENTRIES-1:0] valid_ff, valid_in;
   logic [pnwc_pkg::COLOR_W-1:0]        qr_ff, qg_ff, qb_ff;
   logic [pnwc_pkg::COLOR_W-1:0]        qr_in, qg_in, qb_in;

   logic                                start;
   logic                                issue;
   logic                                ram_we;
   logic                                load_rsp;
   logic                                finish;
   logic                                in_range;
   logic [pnwc_pkg::ADDR_W-1:0]         rd_addr;
   logic [pnwc_pkg::RGB_W-1:0]          ram_q;

   logic                                s1_vld_ff, s1_hit_ff;
   logic [pnwc_pkg::ADDR_W-1:0]         s1_idx_ff;
   logic                                s2_vld_ff;
   logic [pnwc_pkg::ADDR_W-1:0]         s2_idx_ff;
   logic [pnwc_pkg::SQ_W-1:0]           sr_ff, sg_ff, sb_ff;
   logic [pnwc_pkg::SQ_W-1:0]           sr_in, sg_in, sb_in;
   logic                                s3_vld_ff;
   logic [pnwc_pkg::ADDR_W-1:0]         s3_idx_ff;
   logic [pnwc_pkg::DIST_W-1:0]         dist_ff, dist_in;

   logic [pnwc_pkg::DIST_W-1:0]         best_dist_ff, best_dist_in;
   logic [pnwc_pkg::ADDR_W-1:0]         best_idx_ff, best_idx_in;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]                          rsp_tdata_ff;

   logic [pnwc_pkg::RGB_W-1:0]          entry;
   logic [pnwc_pkg::COLOR_W-1:0]        dr, dg, db;

   assign in_range = ({1'b0, cmd.entry_index} < 9'(pnwc_pkg::PALETTE_ENTRIES));
   assign rd_addr  = cnt_ff[pnwc_pkg::ADDR_W-1:0];
   assign finish   = s3_vld_ff &&
                     (s3_idx_ff == pnwc_pkg::ADDR_W'(pnwc_pkg::PALETTE_ENTRIES - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pnwc_pkg::ST_IDLE: begin
            if (cmd_valid && cmd.is_query) begin
               state_in = pnwc_pkg::ST_SEARCH;
            end
         end
         pnwc_pkg::ST_SEARCH: begin
            if (finish) begin
               state_in = pnwc_pkg::ST_RESULT;
            end
         end
         pnwc_pkg::ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = pnwc_pkg::ST_IDLE;
            end
         end
         default: state_in = pnwc_pkg::ST_IDLE;
      endcase
   end

   // Control outputs of the state machine.
   always_comb begin
      cmd_pop  = 1'b0;
      start    = 1'b0;
      ram_we   = 1'b0;
      issue    = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         pnwc_pkg::ST_IDLE: begin
            cmd_pop = cmd_valid;
            start   = cmd_valid && cmd.is_query;
            ram_we  = cmd_valid && !cmd.is_query && in_range;
         end
         pnwc_pkg::ST_SEARCH: begin
            issue = (cnt_ff < pnwc_pkg::CNT_W'(pnwc_pkg::PALETTE_ENTRIES));
         end
         pnwc_pkg::ST_RESULT: begin
            load_rsp = !rsp_tvalid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   pnwc_ram #(
      .WIDTH (pnwc_pkg::RGB_W),
      .DEPTH (pnwc_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cmd.entry_index[pnwc_pkg::ADDR_W-1:0]),
      .wr_data ({cmd.red, cmd.green, cmd.blue}),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // An entry never written since reset reads as black.
   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[cmd.entry_index[pnwc_pkg::ADDR_W-1:0]] = 1'b1;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      qr_in = start ? cmd.red   : qr_ff;
      qg_in = start ? cmd.green : qg_ff;
      qb_in = start ? cmd.blue  : qb_ff;
   end

   // Stage 1: absolute differences and squares.
   always_comb begin
      entry = s1_hit_ff ? ram_q : '0;
      dr = (entry[23:16] >= qr_ff) ? entry[23:16] - qr_ff : qr_ff - entry[23:16];
      dg = (entry[15:8] >= qg_ff) ? entry[15:8] - qg_ff : qg_ff - entry[15:8];
      db = (entry[7:0] >= qb_ff) ? entry[7:0] - qb_ff : qb_ff - entry[7:0];
      sr_in = dr * dr;
      sg_in = dg * dg;
      sb_in = db * db;
   end

   // Stage 2: weighted sum, which stays below 2^23.
   always_comb begin
      dist_in = pnwc_pkg::DIST_W'(pnwc_pkg::WEIGHT_RED * sr_ff)
              + pnwc_pkg::DIST_W'(pnwc_pkg::WEIGHT_GREEN * sg_ff)
              + pnwc_pkg::DIST_W'(pnwc_pkg::WEIGHT_BLUE * sb_ff);
   end

   // Stage 3: strict compare, so a tie keeps the lower index.
   always_comb begin
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (start) begin
         best_dist_in = pnwc_pkg::START_MIN;
         best_idx_in  = '0;
      end else if (s3_vld_ff && (dist_ff < best_dist_ff)) begin
         best_dist_in = dist_ff;
         best_idx_in  = s3_idx_ff;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pnwc_pkg::ST_IDLE;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         valid_ff      <= valid_in;
         s1_vld_ff     <= issue;
         s2_vld_ff     <= s1_vld_ff;
         s3_vld_ff     <= s2_vld_ff;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      qr_ff        <= qr_in;
      qg_ff        <= qg_in;
      qb_ff        <= qb_in;
      s1_idx_ff    <= rd_addr;
      s1_hit_ff    <= valid_ff[rd_addr];
      s2_idx_ff    <= s1_idx_ff;
      sr_ff        <= sr_in;
      sg_ff        <= sg_in;
      sb_ff        <= sb_in;
      s3_idx_ff    <= s2_idx_ff;
      dist_ff      <= dist_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      if (load_rsp) begin
         rsp_tdata_ff <= 8'(best_idx_ff);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= pnwc_pkg::CNT_W'(pnwc_pkg::PALETTE_ENTRIES))
      else $error("search address ran past the palette");

   a_pipe_in_search: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff || s3_vld_ff) |-> (state_ff == pnwc_pkg::ST_SEARCH))
      else $error("distance pipeline busy outside a search");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pnwc_pkg::ST_SEARCH) |-> (best_dist_ff <= pnwc_pkg::START_MIN))
      else $error("running minimum above its start value");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_tvalid_ff)
      else $error("loaded result not presented");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pnwc_pkg::ST_IDLE) |-> !cmd_pop)
      else $error("request taken while a search is open");

endmodule

[rtl/palette_nearest_weighted_color.sv]
// Nearest weighted palette color search: a 256-entry RGB888 palette and a
// search for the entry closest to a query color. Uses pnwc_front, pnwc_back.
// A write request is applied to the palette as the back part takes it from the queue.
// A query runs from the queue through the search to the result register: the
// palette RAM read port scans one entry per cycle through a 3-stage pipeline.
// The back part takes no new request until the last query's result is loaded.
// Synchronous reset empties the queue and marks every palette entry as black.
`timescale 1ns / 1ps

module palette_nearest_weighted_color (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] func
   // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue, [55:32] pixel
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [7:0] nearest_index
);

   logic              cmd_valid;
   logic              cmd_pop;
   pnwc_pkg::cmd_type cmd;

   pnwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   pnwc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[test/tb_palette_nearest_weighted_color.sv]
// Self-checking testbench for palette_nearest_weighted_color: directed and random
// palette writes and queries of all three pixel formats, checked against a local model.
// Depends on pnwc_pkg and the palette_nearest_weighted_color top level only.
`timescale 1ns / 1ps

module tb_palette_nearest_weighted_color;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RX_ALWAYS = 0;
   localparam int RX_RANDOM = 1;
   localparam int RX_PATTERN = 2;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // [1:0] func
   // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue, [55:32] pixel
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // [7:0] nearest_index

   logic [pnwc_pkg::RGB_W-1:0] palette_copy [pnwc_pkg::PALETTE_ENTRIES];
   logic [7:0]                 nearest_q [$];

   int errors = 0;
   int n_writes = 0;
   int n_queries = 0;
   int n_checked = 0;
   int cycle_count = 0;
   int rx_mode = RX_ALWAYS;
   int rx_cycle = 0;
   int hold_len = 0;
   int burst_left = 1;
   bit pacing = 1'b0;

   palette_nearest_weighted_color i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   // Scans the palette in ascending order; only a strictly smaller distance wins.
   function automatic logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
      logic [7:0]  best;
      int unsigned best_dist;
      int unsigned cand_dist;
      int          dr, dg, db;
      best = '0;
      best_dist = pnwc_pkg::START_MIN;
      for (int i = 0; i < pnwc_pkg::PALETTE_ENTRIES; i++) begin
         dr = int'(palette_copy[i][23:16]) - int'(r);
         dg = int'(palette_copy[i][15:8]) - int'(g);
         db = int'(palette_copy[i][7:0]) - int'(b);
         cand_dist = int'(pnwc_pkg::WEIGHT_RED) * dr * dr
                     + int'(pnwc_pkg::WEIGHT_GREEN) * dg * dg
                     + int'(pnwc_pkg::WEIGHT_BLUE) * db * db;
         if (cand_dist < best_dist) begin
            best_dist = cand_dist;
            best = 8'(i);
         end
      end
      return best;
   endfunction

   // Offers one request, waits for its acceptance and updates the model.
   task automatic send_request(input pnwc_pkg::func_type f, input logic [7:0] idx,
                               input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [23:0] pix);
      logic [7:0] qr, qg, qb;
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {pix, b, g, r, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      qr = r;
      qg = g;
      qb = b;
      case (f)
         pnwc_pkg::FUNC_WRITE: begin
            palette_copy[idx] = {r, g, b};
            n_writes++;
         end
         pnwc_pkg::FUNC_PACKED: begin
            qr = {pix[23:19], 3'b000};
            qg = {pix[15:10], 2'b00};
            qb = {pix[7:3], 3'b000};
         end
         pnwc_pkg::FUNC_565: begin
            qr = {pix[15:11], 3'b000};
            qg = {pix[10:5], 2'b00};
            qb = {pix[4:0], 3'b000};
         end
         default: ;
      endcase
      if (f != pnwc_pkg::FUNC_WRITE) begin
         nearest_q.push_back(nearest_entry(qr, qg, qb));
         n_queries++;
      end
      if (pacing) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            req_tvalid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 300)
                                                : $urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   // The sender holds off until every pending query has been answered.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (nearest_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] nudge(input logic [7:0] v);
      int t;
      t = int'(v) + $urandom_range(0, 16) - 8;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return 8'(t);
   endfunction

   task automatic send_random_write();
      send_request(pnwc_pkg::FUNC_WRITE, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)));
   endtask

   // A near query aims close to a palette color so that the search has a real winner.
   task automatic send_random_query(input bit near);
      pnwc_pkg::func_type f;
      logic [23:0]        c, pix;
      logic [7:0]         r, g, b, fr, fg, fb;
      f = pnwc_pkg::func_type'($urandom_range(1, 3));
      c = palette_copy[$urandom_range(0, pnwc_pkg::PALETTE_ENTRIES - 1)];
      r = near ? nudge(c[23:16]) : 8'($urandom_range(0, 255));
      g = near ? nudge(c[15:8]) : 8'($urandom_range(0, 255));
      b = near ? nudge(c[7:0]) : 8'($urandom_range(0, 255));
      fr = 8'($urandom_range(0, 255));
      fg = 8'($urandom_range(0, 255));
      fb = 8'($urandom_range(0, 255));
      pix = 24'($urandom_range(0, 24'hFFFFFF));
      if (f == pnwc_pkg::FUNC_RGB) begin
         fr = r;
         fg = g;
         fb = b;
      end else if (f == pnwc_pkg::FUNC_PACKED && near) begin
         pix = {r, g, b};
      end else if (near) begin
         pix = {pix[23:16], r[7:3], g[7:2], b[7:3]};
      end
      send_request(f, 8'($urandom_range(0, 255)), fr, fg, fb, pix);
   endtask

   // The cleared palette is all black: gray 100 sits exactly at the starting minimum.
   task automatic test_cleared_palette();
      send_request(pnwc_pkg::FUNC_RGB, 8'hA5, 8'd0, 8'd0, 8'd0, 24'h5A5A5A);
      send_request(pnwc_pkg::FUNC_RGB, 8'h5A, 8'd255, 8'd255, 8'd255, 24'hA5A5A5);
      send_request(pnwc_pkg::FUNC_RGB, 8'hFF, 8'd100, 8'd100, 8'd100, 24'h000000);
      send_request(pnwc_pkg::FUNC_PACKED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
      send_request(pnwc_pkg::FUNC_565, 8'hFF, 8'h00, 8'h00, 8'h00, 24'hABFFFF);
      wait_for_results();
   endtask

   task automatic test_extreme_entries();
      send_request(pnwc_pkg::FUNC_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 24'hFFFFFF);
      send_request(pnwc_pkg::FUNC_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 24'h000000);
      send_request(pnwc_pkg::FUNC_WRITE, 8'd128, 8'd255, 8'd0, 8'd0, 24'h123456);
      send_request(pnwc_pkg::FUNC_RGB, 8'd0, 8'd255, 8'd255, 8'd255, 24'hFFFFFF);
      send_request(pnwc_pkg::FUNC_RGB, 8'd255, 8'd255, 8'd0, 8'd0, 24'h000000);
      send_request(pnwc_pkg::FUNC_RGB, 8'd77, 8'd0, 8'd0, 8'd0, 24'hFFFFFF);
      wait_for_results();
   endtask

   // Equal colors at two indexes, then single-channel offsets that only the weights separate.
   task automatic test_tie_and_weights();
      send_request(pnwc_pkg::FUNC_WRITE, 8'd20, 8'd60, 8'd60, 8'd60, 24'h0);
      send_request(pnwc_pkg::FUNC_WRITE, 8'd10, 8'd60, 8'd60, 8'd60, 24'h0);
      send_request(pnwc_pkg::FUNC_RGB, 8'd0, 8'd60, 8'd60, 8'd60, 24'h0);
      send_request(pnwc_pkg::FUNC_WRITE, 8'd40, 8'd200, 8'd90, 8'd90, 24'h0);
      send_request(pnwc_pkg::FUNC_WRITE, 8'd41, 8'd190, 8'd100, 8'd90, 24'h0);
      send_request(pnwc_pkg::FUNC_WRITE, 8'd42, 8'd190, 8'd90, 8'd100, 24'h0);
      send_request(pnwc_pkg::FUNC_RGB, 8'd0, 8'd190, 8'd90, 8'd90, 24'h0);
      wait_for_results();
   endtask

   task automatic test_pixel_formats();
      send_request(pnwc_pkg::FUNC_WRITE, 8'd50, 8'd248, 8'd252, 8'd248, 24'h0);
      send_request(pnwc_pkg::FUNC_PACKED, 8'd1, 8'd2, 8'd3, 8'd4, 24'hF8FCF8);
      send_request(pnwc_pkg::FUNC_PACKED, 8'd9, 8'd0, 8'd0, 8'd0, 24'hFFFFFF);
      send_request(pnwc_pkg::FUNC_PACKED, 8'd9, 8'd255, 8'd255, 8'd255, 24'h070307);
      send_request(pnwc_pkg::FUNC_565, 8'd3, 8'd0, 8'd0, 8'd0, 24'h5AFFFF);
      send_request(pnwc_pkg::FUNC_565, 8'd3, 8'd255, 8'd255, 8'd255, 24'hFFF800);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count);
      int pick;
      pacing = 1'b1;
      burst_left = 1;
      for (int n = 0; n < count; n++) begin
         if (n % 80 == 0) rx_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
         pick = $urandom_range(0, 99);
         if (pick < 45) send_random_write();
         else send_random_query(pick < 75);
      end
      pacing = 1'b0;
      wait_for_results();
   endtask

   // The receiver stops for a long stretch so that the request queue fills and stalls.
   task automatic test_backpressure();
      rx_mode = RX_ALWAYS;
      hold_len = 1500;
      for (int n = 0; n < 6; n++) send_random_query(1'b1);
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_len = hold_len - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_RANDOM:  rsp_tready <= ($urandom_range(0, 9) >= 3);
            RX_PATTERN: rsp_tready <= ((rx_cycle % 11) >= 4);
            default:    rsp_tready <= 1'b1;
         endcase
      end
      rx_cycle++;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (nearest_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no query pending", rsp_tdata));
         end else begin
            if (rsp_tdata !== nearest_q[0])
               report_mismatch($sformatf("nearest_index got %0d, expected %0d",
                                         rsp_tdata, nearest_q[0]));
            void'(nearest_q.pop_front());
            n_checked++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("palette_nearest_weighted_color: mismatch");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      for (int i = 0; i < pnwc_pkg::PALETTE_ENTRIES; i++) palette_copy[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cleared_palette();
      test_extreme_entries();
      test_tie_and_weights();
      test_pixel_formats();
      test_random_traffic(400);
      test_backpressure();

      repeat (pnwc_pkg::PALETTE_ENTRIES + 50) @(posedge clock);
      if (nearest_q.size() != 0)
         report_mismatch($sformatf("%0d queries never answered", nearest_q.size()));
      $display("Covered %0d palette writes and %0d queries in RGB, packed and 5-6-5 form;",
               n_writes, n_queries);
      $display("%0d results checked under input bursts, output stalls and a long hold-off.",
               n_checked);
      if (errors == 0) $display("palette_nearest_weighted_color: match");
      else $display("palette_nearest_weighted_color: mismatch");
      $finish;
   end

endmodule
